// File: rtl/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define SRA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define SRA_ASSERT(lbl, prop)
`define SRA_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/sra_pkg.sv
// types, constants and the arctangent table of the rotation angle block
package sra_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 16;
  localparam int unsigned CORDIC_STAGES   = 16;
  localparam int unsigned TABLE_LEN       = 24;
  localparam int unsigned N_CORDIC  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int unsigned GUARD_BITS = 4;

  localparam int unsigned COORD_W = 20;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned SUM_W   = SQ_W + 1;
  localparam int unsigned NUM_W   = SUM_W + 3;
  localparam int unsigned Q_W     = 2 * ANGLE_FRAC_BITS;
  localparam int unsigned ROOT_W  = ANGLE_FRAC_BITS;
  localparam int unsigned REM_W   = ANGLE_FRAC_BITS + 2;
  localparam int unsigned A_W     = ANGLE_FRAC_BITS + 1;
  localparam int unsigned CW      = ANGLE_FRAC_BITS + GUARD_BITS + 4;
  localparam int unsigned ZW      = ANGLE_FRAC_BITS + 3;
  localparam int unsigned T_W     = ANGLE_FRAC_BITS + 1;
  localparam int unsigned ANG_W   = ANGLE_FRAC_BITS + 3;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned RES_W   = 19;
  localparam int unsigned LANE_LAT = 4 * ANGLE_FRAC_BITS + N_CORDIC + 3;
  localparam int unsigned SHIFT   = 30 - ANGLE_FRAC_BITS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [NUM_W-1:0]          num_t;
  typedef logic [Q_W-1:0]            quo_t;
  typedef logic [ROOT_W-1:0]         root_t;
  typedef logic [REM_W-1:0]          rem_t;
  typedef logic [A_W-1:0]            a_t;
  typedef logic signed [CW-1:0]      cw_t;
  typedef logic signed [ZW-1:0]      z_t;
  typedef logic [T_W-1:0]            t_t;
  typedef logic [ANG_W-1:0]          ang_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [RES_W-1:0]   res_t;

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] ROUND_Q30 = 64'd1 << (SHIFT - 1);
  localparam ang_t PI_ANG     = ang_t'((PI_Q30 + ROUND_Q30) >> SHIFT);
  localparam ang_t TWO_PI_ANG = {PI_ANG[ANG_W-2:0], 1'b0};
  localparam t_t   HALF_PI_T  = t_t'(((PI_Q30 >> 1) + ROUND_Q30) >> SHIFT);

  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
  };

  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  typedef struct packed {
    logic r2_zero;
    logic clamp;
    logic dx1_neg;
    logic dy1_neg;
    logic dx2_neg;
    logic dy2_neg;
    logic tie_neg;
  } side_t;

  function automatic z_t atan_angle(input idx_t idx);
    logic [63:0] v;
    v = (32'(idx) < TABLE_LEN) ? 64'(ATAN_Q30[idx]) : 64'd0;
    return z_t'((v + ROUND_Q30) >> SHIFT);
  endfunction

endpackage

// File: rtl/sra_div_cell.sv
// one restoring division step of the ratio chain
module sra_div_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  sra_pkg::num_t   rem_i,
  input  sra_pkg::quo_t   quo_i,
  input  sra_pkg::num_t   den_i,
  output sra_pkg::num_t   rem_o,
  output sra_pkg::quo_t   quo_o,
  output sra_pkg::num_t   den_o
);

  logic [sra_pkg::NUM_W:0] rem2;
  logic [sra_pkg::NUM_W:0] den2;
  logic [sra_pkg::NUM_W:0] diff;
  logic                    ge;
  sra_pkg::num_t           rem_d, rem_q, den_q;
  sra_pkg::quo_t           quo_d, quo_q;

  assign rem2  = {rem_i, 1'b0};
  assign den2  = {1'b0, den_i};
  assign diff  = rem2 - den2;
  assign ge    = rem2 >= den2;
  assign rem_d = ge ? sra_pkg::num_t'(diff) : sra_pkg::num_t'(rem2);
  assign quo_d = {quo_i[sra_pkg::Q_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

// File: rtl/sra_sqrt_cell.sv
// one digit step of the integer square root chain
module sra_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  sra_pkg::quo_t   val_i,
  input  sra_pkg::rem_t   rem_i,
  input  sra_pkg::root_t  root_i,
  output sra_pkg::quo_t   val_o,
  output sra_pkg::rem_t   rem_o,
  output sra_pkg::root_t  root_o
);

  logic [sra_pkg::REM_W+1:0] rem2;
  logic [sra_pkg::REM_W+1:0] trial;
  logic                      ge;
  sra_pkg::quo_t             val_q;
  sra_pkg::rem_t             rem_d, rem_q;
  sra_pkg::root_t            root_d, root_q;

  assign rem2   = {rem_i, val_i[sra_pkg::Q_W-1 -: 2]};
  assign trial  = {2'b00, root_i, 2'b01};
  assign ge     = rem2 >= trial;
  assign rem_d  = ge ? sra_pkg::rem_t'(rem2 - trial) : sra_pkg::rem_t'(rem2);
  assign root_d = {root_i[sra_pkg::ROOT_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= {val_i[sra_pkg::Q_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign val_o  = val_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// File: rtl/sra_cordic_cell.sv
// one vectoring rotation of the arcsine chain
module sra_cordic_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  sra_pkg::idx_t  stage_i,
  input  sra_pkg::cw_t   x_i,
  input  sra_pkg::cw_t   y_i,
  input  sra_pkg::z_t    z_i,
  output sra_pkg::cw_t   x_o,
  output sra_pkg::cw_t   y_o,
  output sra_pkg::z_t    z_o
);

  sra_pkg::cw_t xs, ys, x_d, y_d, x_q, y_q;
  sra_pkg::z_t  t, z_d, z_q;

  assign xs = x_i >>> stage_i;
  assign ys = y_i >>> stage_i;
  assign t  = sra_pkg::atan_angle(stage_i);

  always_comb begin
    if (!y_i[sra_pkg::CW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + t;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// File: rtl/sra_asin_lane.sv
// arcsine of sqrt(num/den): division, two root chains and a cordic chain
module sra_asin_lane (
  input  logic           clk_i,
  input  logic           en_i,
  input  sra_pkg::num_t  num_i,
  input  sra_pkg::num_t  den_i,
  output sra_pkg::t_t    t_o
);

  localparam int unsigned F  = sra_pkg::ANGLE_FRAC_BITS;
  localparam int unsigned QW = sra_pkg::Q_W;
  localparam int unsigned NC = sra_pkg::N_CORDIC;

  sra_pkg::num_t  rem_w [QW+1];
  sra_pkg::quo_t  quo_w [QW+1];
  sra_pkg::num_t  den_w [QW+1];
  sra_pkg::quo_t  val1_w [F+1];
  sra_pkg::rem_t  rem1_w [F+1];
  sra_pkg::root_t root1_w [F+1];
  sra_pkg::quo_t  val2_w [F+1];
  sra_pkg::rem_t  rem2_w [F+1];
  sra_pkg::root_t root2_w [F+1];
  sra_pkg::cw_t   x_w [NC+1];
  sra_pkg::cw_t   y_w [NC+1];
  sra_pkg::z_t    z_w [NC+1];

  logic [3*F-1:0] spec_q;
  sra_pkg::a_t    a_q, a_m_q;
  sra_pkg::quo_t  sq, s_q;
  logic           zero_m_q, full_m_q;
  sra_pkg::a_t    a_line_q [F];
  logic [F-1:0]   zero_l_q, full_l_q;
  logic [NC-1:0]  zero_c_q, full_c_q;
  sra_pkg::z_t    z_end;
  sra_pkg::t_t    t_d, t_q;

  assign rem_w[0] = num_i;
  assign quo_w[0] = '0;
  assign den_w[0] = den_i;

  for (genvar g = 0; g < QW; g++) begin : g_div
    sra_div_cell u_cell (
      .clk_i, .en_i,
      .rem_i (rem_w[g]),   .quo_i (quo_w[g]),   .den_i (den_w[g]),
      .rem_o (rem_w[g+1]), .quo_o (quo_w[g+1]), .den_o (den_w[g+1])
    );
  end

  assign val1_w[0]  = quo_w[QW];
  assign rem1_w[0]  = '0;
  assign root1_w[0] = '0;

  for (genvar g = 0; g < F; g++) begin : g_root1
    sra_sqrt_cell u_cell (
      .clk_i, .en_i,
      .val_i (val1_w[g]),   .rem_i (rem1_w[g]),   .root_i (root1_w[g]),
      .val_o (val1_w[g+1]), .rem_o (rem1_w[g+1]), .root_o (root1_w[g+1])
    );
  end

  // ratio of one or above is taken as exactly one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec_q <= {spec_q[3*F-2:0], num_i >= den_i};
      a_q    <= spec_q[3*F-1] ? sra_pkg::a_t'(1) << F : {1'b0, root1_w[F]};
    end
  end

  assign sq = sra_pkg::quo_t'(a_q[F-1:0]) * sra_pkg::quo_t'(a_q[F-1:0]);

  // one minus a squared, wrapping is harmless as a zero angle is forced
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q      <= '0 - sq;
      a_m_q    <= a_q;
      zero_m_q <= a_q == '0;
      full_m_q <= a_q[F];
    end
  end

  assign val2_w[0]  = s_q;
  assign rem2_w[0]  = '0;
  assign root2_w[0] = '0;

  for (genvar g = 0; g < F; g++) begin : g_root2
    sra_sqrt_cell u_cell (
      .clk_i, .en_i,
      .val_i (val2_w[g]),   .rem_i (rem2_w[g]),   .root_i (root2_w[g]),
      .val_o (val2_w[g+1]), .rem_o (rem2_w[g+1]), .root_o (root2_w[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_line_q[0] <= a_m_q;
      for (int k = 1; k < F; k++) begin
        a_line_q[k] <= a_line_q[k-1];
      end
      zero_l_q <= {zero_l_q[F-2:0], zero_m_q};
      full_l_q <= {full_l_q[F-2:0], full_m_q};
      zero_c_q <= {zero_c_q[NC-2:0], zero_l_q[F-1]};
      full_c_q <= {full_c_q[NC-2:0], full_l_q[F-1]};
    end
  end

  assign x_w[0] = sra_pkg::cw_t'({root2_w[F], {sra_pkg::GUARD_BITS{1'b0}}});
  assign y_w[0] = sra_pkg::cw_t'({a_line_q[F-1][F-1:0], {sra_pkg::GUARD_BITS{1'b0}}});
  assign z_w[0] = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    sra_cordic_cell u_cell (
      .clk_i, .en_i,
      .stage_i (sra_pkg::idx_t'(g)),
      .x_i (x_w[g]),   .y_i (y_w[g]),   .z_i (z_w[g]),
      .x_o (x_w[g+1]), .y_o (y_w[g+1]), .z_o (z_w[g+1])
    );
  end

  assign z_end = z_w[NC];

  always_comb begin
    priority if (zero_c_q[NC-1]) begin
      t_d = '0;
    end else if (full_c_q[NC-1]) begin
      t_d = sra_pkg::HALF_PI_T;
    end else if (z_end[sra_pkg::ZW-1]) begin
      t_d = '0;
    end else if (z_end > sra_pkg::z_t'(sra_pkg::HALF_PI_T)) begin
      t_d = sra_pkg::HALF_PI_T;
    end else begin
      t_d = sra_pkg::t_t'(z_end);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

// File: rtl/signed_rotation_angle.sv
// signed rotation angle between two points about a configured centre
//
// Input channel: one beat carries both points (Q16.4); it is taken when
// in_valid_i is high and in_stall_o is low. Output channel: one beat per
// input beat with rotation_angle_o (2^-16 rad, negative clockwise) and
// invalid_o, taken when out_valid_o is high and out_stall_i is low.
// Configuration: cfg_index_i selects centre x (0) or centre y (1), written
// when cfg_valid_i is high; cfg_ready_o is always high. Write only while idle.
// Throughput: one beat per cycle while in_stall_o is low. Stages: 3 front
// stages, then the arcsine lanes (F fraction bits, N cordic stages), then
// one output register. The lane depth is set by the division, the two root
// chains and the cordic chain.
// Reset clears all valid bits and the centre to zero; no clearing pass.
// When the receiver stalls, one skid entry catches the beat that reaches
// the output; while it is full the whole pipeline holds and in_stall_o is high.
`include "assert_macros.svh"

module signed_rotation_angle (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [19:0]     first_x_i,
  input  logic signed [19:0]     first_y_i,
  input  logic signed [19:0]     second_x_i,
  input  logic signed [19:0]     second_y_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [18:0]     rotation_angle_o,
  output logic                   invalid_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic signed [19:0]     cfg_data_i
);

  localparam int unsigned LAT = sra_pkg::LANE_LAT;

  sra_pkg::coord_t center_x_q, center_y_q;
  logic            en;

  sra_pkg::diff_t  dx1, dy1, dx2, dy2, cx, cy;
  sra_pkg::diff_t  dx1_q, dy1_q, dy2_q, cx_q, cy_q;
  logic signed [2*sra_pkg::DIFF_W-1:0] p_dx1, p_dy1, p_dy2, p_cx, p_cy;
  sra_pkg::sq_t    dx1_sq_q, dy1_sq_q, dy2_sq_q, cx_sq_q, cy_sq_q;
  sra_pkg::sum_t   r2, d2;
  sra_pkg::num_t   num_m_q, den_m_q, num_1_q, den_1_q, num_2_q, den_2_q;
  sra_pkg::side_t  side0, side0_q, side1_q, side2_d, side2_q, side_f;
  logic            v0_q, v1_q, v2_q;
  logic [LAT-1:0]  v_line_q;
  sra_pkg::side_t  side_line_q [LAT];
  sra_pkg::t_t     t_m, t_1, t_2;
  sra_pkg::ang_t   a1, a2;
  logic            neg, push;
  sra_pkg::res_t   mag;
  sra_pkg::res_t   res;
  logic            inv;
  logic            out_valid_q, skid_full_q;
  sra_pkg::res_t   out_angle_q, skid_angle_q;
  logic            out_inv_q, skid_inv_q;

  function automatic sra_pkg::ang_t polar(input sra_pkg::t_t t, input logic x_neg,
                                          input logic y_neg);
    sra_pkg::ang_t tt;
    tt = sra_pkg::ang_t'(t);
    if (!x_neg) begin
      return y_neg ? sra_pkg::TWO_PI_ANG - tt : tt;
    end
    return y_neg ? sra_pkg::PI_ANG + tt : sra_pkg::PI_ANG - tt;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sra_pkg::REG_CENTER_X: center_x_q <= cfg_data_i;
        sra_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i;
        default:               center_x_q <= center_x_q;
      endcase
    end
  end

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // front: differences, squares, sums
  assign dx1 = sra_pkg::diff_t'(first_x_i) - sra_pkg::diff_t'(center_x_q);
  assign dy1 = sra_pkg::diff_t'(first_y_i) - sra_pkg::diff_t'(center_y_q);
  assign dx2 = sra_pkg::diff_t'(second_x_i) - sra_pkg::diff_t'(center_x_q);
  assign dy2 = sra_pkg::diff_t'(second_y_i) - sra_pkg::diff_t'(center_y_q);
  assign cx  = sra_pkg::diff_t'(first_x_i) - sra_pkg::diff_t'(second_x_i);
  assign cy  = sra_pkg::diff_t'(first_y_i) - sra_pkg::diff_t'(second_y_i);

  always_comb begin
    side0         = '0;
    side0.dx1_neg = dx1[sra_pkg::DIFF_W-1];
    side0.dy1_neg = dy1[sra_pkg::DIFF_W-1];
    side0.dx2_neg = dx2[sra_pkg::DIFF_W-1];
    side0.dy2_neg = dy2[sra_pkg::DIFF_W-1];
    // tie break on equal polar angles
    side0.tie_neg = (dy1 > 0) ? (second_x_i > first_x_i) : (second_x_i < first_x_i);
  end

  assign p_dx1 = dx1_q * dx1_q;
  assign p_dy1 = dy1_q * dy1_q;
  assign p_dy2 = dy2_q * dy2_q;
  assign p_cx  = cx_q * cx_q;
  assign p_cy  = cy_q * cy_q;

  assign r2 = sra_pkg::sum_t'(dx1_sq_q) + sra_pkg::sum_t'(dy1_sq_q);
  assign d2 = sra_pkg::sum_t'(cx_sq_q) + sra_pkg::sum_t'(cy_sq_q);

  always_comb begin
    side2_d         = side1_q;
    side2_d.r2_zero = r2 == '0;
    side2_d.clamp   = (sra_pkg::num_t'(d2) > sra_pkg::num_t'({r2, 2'b00}))
                      || (sra_pkg::sum_t'(dy1_sq_q) > r2)
                      || (sra_pkg::sum_t'(dy2_sq_q) > r2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v_line_q <= '0;
    end else if (en) begin
      v0_q     <= in_valid_i;
      v1_q     <= v0_q;
      v2_q     <= v1_q;
      v_line_q <= {v_line_q[LAT-2:0], v2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q   <= dx1;
      dy1_q   <= dy1;
      dy2_q   <= dy2;
      cx_q    <= cx;
      cy_q    <= cy;
      side0_q <= side0;

      dx1_sq_q <= sra_pkg::sq_t'(p_dx1);
      dy1_sq_q <= sra_pkg::sq_t'(p_dy1);
      dy2_sq_q <= sra_pkg::sq_t'(p_dy2);
      cx_sq_q  <= sra_pkg::sq_t'(p_cx);
      cy_sq_q  <= sra_pkg::sq_t'(p_cy);
      side1_q  <= side0_q;

      num_m_q <= sra_pkg::num_t'(d2);
      den_m_q <= sra_pkg::num_t'({r2, 2'b00});
      num_1_q <= sra_pkg::num_t'(dy1_sq_q);
      den_1_q <= sra_pkg::num_t'(r2);
      num_2_q <= sra_pkg::num_t'(dy2_sq_q);
      den_2_q <= sra_pkg::num_t'(r2);
      side2_q <= side2_d;

      side_line_q[0] <= side2_q;
      for (int k = 1; k < LAT; k++) begin
        side_line_q[k] <= side_line_q[k-1];
      end
    end
  end

  sra_asin_lane u_lane_mag (
    .clk_i, .en_i (en), .num_i (num_m_q), .den_i (den_m_q), .t_o (t_m)
  );

  sra_asin_lane u_lane_first (
    .clk_i, .en_i (en), .num_i (num_1_q), .den_i (den_1_q), .t_o (t_1)
  );

  sra_asin_lane u_lane_second (
    .clk_i, .en_i (en), .num_i (num_2_q), .den_i (den_2_q), .t_o (t_2)
  );

  // back: quadrant fold, sign and result
  assign side_f = side_line_q[LAT-1];
  assign a1     = polar(t_1, side_f.dx1_neg, side_f.dy1_neg);
  assign a2     = polar(t_2, side_f.dx2_neg, side_f.dy2_neg);
  assign neg    = (a2 < a1) || ((a2 == a1) && side_f.tie_neg);
  assign mag    = sra_pkg::res_t'({t_m, 1'b0});

  always_comb begin
    if (side_f.r2_zero) begin
      res = '0;
      inv = 1'b1;
    end else begin
      res = neg ? sra_pkg::res_t'('0 - mag) : mag;
      inv = side_f.clamp;
    end
  end

  assign push = en && v_line_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_full_q) begin
        out_valid_q <= 1'b1;
        skid_full_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_full_q) begin
        out_angle_q <= skid_angle_q;
        out_inv_q   <= skid_inv_q;
      end else if (push) begin
        out_angle_q <= res;
        out_inv_q   <= inv;
      end
    end else if (push) begin
      skid_angle_q <= res;
      skid_inv_q   <= inv;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rotation_angle_o = out_angle_q;
  assign invalid_o        = out_inv_q;

  `SRA_ASSERT(a_skid_needs_out, skid_full_q |-> out_valid_q)
  `SRA_ASSERT(a_skid_drains, (skid_full_q && !out_stall_i) |=> (out_valid_q && !skid_full_q))
  `SRA_ASSERT_RST(a_cfg_always_ready, cfg_ready_o)

endmodule
